>>> rtl/hsa_pkg.sv
package hsa_pkg;

  localparam int CHAN_W = 8;
  localparam int HSL_W = 17;
  localparam int T6_W = 19;
  localparam int unsigned ONE = 65536;
  localparam int unsigned HALF = 32768;

  localparam logic [1:0] REG_HUE_SHIFT = 2'd0;
  localparam logic [1:0] REG_SAT_GAIN = 2'd1;
  localparam logic [1:0] REG_LIGHT_SHIFT = 2'd2;

  typedef logic [HSL_W-1:0] frac_t;
  typedef logic [T6_W-1:0] t6_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // piecewise hue ramp between p and q, t6 in sixths of a turn
  function automatic frac_t chan_val(input frac_t p, input frac_t q, input t6_t t6);
    frac_t span;
    frac_t k;
    logic [2*HSL_W-1:0] pr;
    span = q - p;
    k = (t6 < T6_W'(ONE)) ? t6[HSL_W-1:0] : HSL_W'(T6_W'(4 * ONE) - t6);
    pr = span * k;
    if (t6 < T6_W'(ONE) || (t6 >= T6_W'(3 * ONE) && t6 < T6_W'(4 * ONE))) begin
      chan_val = p + HSL_W'((pr + (2*HSL_W)'(HALF)) >> 16);
    end else if (t6 < T6_W'(3 * ONE)) begin
      chan_val = q;
    end else begin
      chan_val = p;
    end
  endfunction

  function automatic chan_t to_chan(input frac_t c);
    logic [24:0] x;
    logic [8:0] o;
    x = {c, 8'd0} - 25'(c) + 25'(HALF);
    o = 9'(x >> 16);
    to_chan = (o > 9'd255) ? 8'hFF : o[7:0];
  endfunction

endpackage

>>> rtl/hsa_div.sv
module hsa_div #(
  parameter int NW = 25,
  parameter int DW = 9,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [1:QW-1];
  logic [DW-1:0] dv_r  [1:QW-1];
  logic [QW-1:0] qt_r  [1:QW];
  logic [QW-1:0] low_r [1:QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_c;
    logic [DW-1:0] dv_c;
    logic [QW-1:0] qt_c;
    logic [QW-1:0] low_c;
    logic [DW:0] trial;
    logic ge;

    if (i == 0) begin : g_first
      assign rem_c = DW'(num[NW-1:QW]);
      assign dv_c = den;
      assign qt_c = '0;
      assign low_c = num[QW-1:0];
    end else begin : g_next
      assign rem_c = rem_r[i];
      assign dv_c = dv_r[i];
      assign qt_c = qt_r[i];
      assign low_c = low_r[i];
    end

    // one quotient bit per stage
    assign trial = {rem_c, low_c[QW-1]};
    assign ge = trial >= {1'b0, dv_c};

    always_ff @(posedge clk) begin
      if (en) begin
        qt_r[i+1] <= {qt_c[QW-2:0], ge};
      end
    end

    if (i < QW - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? DW'(trial - {1'b0, dv_c}) : trial[DW-1:0];
          dv_r[i+1] <= dv_c;
          low_r[i+1] <= {low_c[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qt_r[QW];

endmodule

>>> rtl/hsl_hue_saturation_adjust.sv
// hsl hue / saturation / lightness adjust of one rgba pixel per clock.
// input channel: in_valid, in_stall and red_in/green_in/blue_in/alpha_in.
// output channel: out_valid, out_stall and red_out/green_out/blue_out/alpha_out.
// an item is taken on a clock edge where valid is high and stall is low.
// registers hue_shift (index 0), saturation_gain (1) and lightness_shift (2)
// are written through wr_en / wr_index / wr_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// 22 register stages: one input stage for the min/max, numerators and the
// lightness (reciprocal multiply), 17 divider stages (one quotient bit per
// stage, saturation and hue dividers side by side), then four stages for the
// adjust, the q/p multiply, the hue ramp and the rescale.
// throughput is one item per clock while the output is not stalled.
// while out_valid is high and out_stall is high the whole pipeline holds and
// in_stall goes high; no item is dropped or repeated.
// synchronous reset clears all valid bits and loads the register defaults:
// hue shift 0, saturation gain 256 (1.0), lightness shift 0.
module hsl_hue_saturation_adjust (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [9:0] wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out
);

  localparam int DIV_Q = 17;
  localparam int NSTAGE = DIV_Q + 5;

  logic signed [8:0] hue_shift;
  logic [9:0] saturation_gain;
  logic signed [8:0] lightness_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift <= '0;
      saturation_gain <= 10'd256;
      lightness_shift <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        hsa_pkg::REG_HUE_SHIFT:   hue_shift <= wr_data[8:0];
        hsa_pkg::REG_SAT_GAIN:    saturation_gain <= wr_data;
        hsa_pkg::REG_LIGHT_SHIFT: lightness_shift <= wr_data[8:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [NSTAGE-1:0] vld;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // stage a: extremes, hue numerator, divider operands
  logic [7:0] mx, mn, dd, dn;
  logic [8:0] ss;
  logic [10:0] d2, d4, d6, nn;

  always_comb begin
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx) mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    dd = mx - mn;
    ss = {1'b0, mx} + {1'b0, mn};
    dn = (ss <= 9'd255) ? ss[7:0] : 8'(9'd510 - ss);
    d2 = {2'b0, dd, 1'b0};
    d4 = {1'b0, dd, 2'b0};
    d6 = d4 + d2;
    priority if (mx == red_in) begin
      nn = (green_in >= blue_in) ? 11'(green_in - blue_in)
                                 : d6 - 11'(blue_in - green_in);
    end else if (mx == green_in) begin
      nn = d2 + 11'(blue_in) - 11'(red_in);
    end else begin
      nn = d4 + 11'(red_in) - 11'(green_in);
    end
  end

  // lightness (s*65536 + 255) / 510 = 128*s + (128*s + 127) / 255,
  // the small quotient by 255 through (y + (y >> 8) + 1) >> 8
  logic [15:0] ly;
  logic [16:0] lt;
  hsa_pkg::frac_t l_c;

  assign ly = {ss, 7'd0} + 16'd127;
  assign lt = (17'(ly) + 17'(ly[15:8]) + 17'd1) >> 8;
  assign l_c = 17'({ss, 7'd0}) + lt;

  logic [23:0] s_num;
  logic [7:0] s_den;
  logic [26:0] h_num;
  logic [10:0] h_den;
  logic [7:0] alpha_a;
  logic gray_a;
  hsa_pkg::frac_t l_a;

  always_ff @(posedge clk) begin
    if (en) begin
      l_a <= l_c;
      s_num <= {dd, 16'd0} + 24'(dn >> 1);
      s_den <= (dd == 8'd0) ? 8'd1 : dn;
      h_num <= {nn, 16'd0} + 27'(d2 + {3'b0, dd});
      h_den <= (dd == 8'd0) ? 11'd6 : d6;
      alpha_a <= alpha_in;
      gray_a <= (dd == 8'd0);
    end
  end

  hsa_pkg::frac_t lq, sq, hq;

  hsa_div #(.NW(24), .DW(8), .QW(DIV_Q)) u_div_s (
    .clk(clk), .en(en), .num(s_num), .den(s_den), .quo(sq)
  );
  hsa_div #(.NW(27), .DW(11), .QW(DIV_Q)) u_div_h (
    .clk(clk), .en(en), .num(h_num), .den(h_den), .quo(hq)
  );

  // lightness, gray flag and alpha ride beside the dividers
  logic [25:0] side_r [1:DIV_Q];

  for (genvar i = 1; i <= DIV_Q; i++) begin : g_side
    if (i == 1) begin : g_head
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[i] <= {l_a, gray_a, alpha_a};
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[i] <= side_r[i-1];
        end
      end
    end
  end

  assign lq = side_r[DIV_Q][25:9];

  // stage p1: hue turn, saturation gain, lightness move
  logic signed [18:0] hs, hw;
  logic [26:0] sg;
  logic [18:0] sr;
  logic [7:0] lf;
  logic [24:0] lp, pp;
  hsa_pkg::frac_t l_neg, l_pos;
  logic gray_d;

  assign gray_d = side_r[DIV_Q][8];

  always_comb begin
    hs = $signed({2'b0, hq}) + $signed({{2{hue_shift[8]}}, hue_shift, 8'd0});
    priority if (hs < 0) begin
      hw = hs + 19'sd65536;
    end else if (hs > 19'sd65536) begin
      hw = hs - 19'sd65536;
    end else begin
      hw = hs;
    end
    sg = sq * saturation_gain;
    sr = 19'((sg + 27'd128) >> 8);
    lf = 8'(9'd256 + lightness_shift);
    lp = lq * lf;
    pp = (17'(hsa_pkg::ONE) - lq) * lightness_shift[7:0];
    l_neg = 17'((lp + 25'd128) >> 8);
    l_pos = lq + 17'((pp + 25'd128) >> 8);
  end

  logic [15:0] h1;
  hsa_pkg::frac_t s1, l1;
  logic [7:0] alpha_1;

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= hw[15:0];
      s1 <= gray_d ? '0 : ((sr > 19'd65536) ? 17'(hsa_pkg::ONE) : sr[16:0]);
      l1 <= lightness_shift[8] ? l_neg : l_pos;
      alpha_1 <= side_r[DIV_Q][7:0];
    end
  end

  // stage p2: q and p, hue phase per channel
  hsa_pkg::frac_t am, qv;
  logic [33:0] prod;
  logic [17:0] p2;
  hsa_pkg::t6_t h6;

  always_comb begin
    am = (l1 < 17'(hsa_pkg::HALF)) ? l1 : 17'(hsa_pkg::ONE) - l1;
    prod = am * s1;
    qv = l1 + 17'((prod + 34'd32768) >> 16);
    p2 = {l1, 1'b0} - {1'b0, qv};
    h6 = 19'({h1, 2'b0}) + 19'({h1, 1'b0});
  end

  hsa_pkg::frac_t p_2, q_2, l_2;
  hsa_pkg::t6_t tr_2, tg_2, tb_2;
  logic gray_2;
  logic [7:0] alpha_2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_2 <= p2[16:0];
      q_2 <= qv;
      l_2 <= l1;
      tg_2 <= h6;
      tr_2 <= (h6 >= 19'd262144) ? h6 - 19'd262144 : h6 + 19'd131072;
      tb_2 <= (h6 >= 19'd131072) ? h6 - 19'd131072 : h6 + 19'd262144;
      gray_2 <= (s1 == '0);
      alpha_2 <= alpha_1;
    end
  end

  // stage p3: channel ramps
  hsa_pkg::frac_t cr_3, cg_3, cb_3;
  logic [7:0] alpha_3;

  always_ff @(posedge clk) begin
    if (en) begin
      cr_3 <= gray_2 ? l_2 : hsa_pkg::chan_val(p_2, q_2, tr_2);
      cg_3 <= gray_2 ? l_2 : hsa_pkg::chan_val(p_2, q_2, tg_2);
      cb_3 <= gray_2 ? l_2 : hsa_pkg::chan_val(p_2, q_2, tb_2);
      alpha_3 <= alpha_2;
    end
  end

  // stage p4: rescale to channel range, output register
  always_ff @(posedge clk) begin
    if (en) begin
      red_out <= hsa_pkg::to_chan(cr_3);
      green_out <= hsa_pkg::to_chan(cg_3);
      blue_out <= hsa_pkg::to_chan(cb_3);
      alpha_out <= alpha_3;
    end
  end

endmodule

>>> rtl/hsa_checker.sv
module hsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out
);

  // input side only holds off when a finished item is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked output item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled item dropped");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(red_out) && $stable(green_out)
                                  && $stable(blue_out) && $stable(alpha_out)))
    else $error("stalled item changed");

endmodule

bind hsl_hue_saturation_adjust hsa_checker u_hsa_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .red_out(red_out),
  .green_out(green_out),
  .blue_out(blue_out),
  .alpha_out(alpha_out)
);

>>> test/tb_hsl_hue_saturation_adjust.sv
`timescale 1ns / 1ps

module tb_hsl_hue_saturation_adjust;

  localparam int LATENCY = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit [7:0] r, g, b, a;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [9:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out, green_out, blue_out, alpha_out;

  // shadow of the block registers
  bit [8:0] hue_reg = '0;
  bit [9:0] gain_reg = 10'd256;
  bit [8:0] light_reg = '0;

  int unsigned cycle_count = 0;
  bit start_hold = 1'b0;
  bit long_hold = 1'b0;
  int unsigned sink_idle_max = 3;
  int unsigned sink_wait = 0;

  hsl_hue_saturation_adjust dut (.*);

  always #10 clk = ~clk;

  function automatic longint unsigned ramp(longint unsigned p, longint unsigned q,
                                           longint unsigned t6);
    if (t6 < hsa_pkg::ONE) return p + (((q - p) * t6 + hsa_pkg::HALF) >> 16);
    if (t6 < 3 * hsa_pkg::ONE) return q;
    if (t6 < 4 * hsa_pkg::ONE)
      return p + (((q - p) * (4 * hsa_pkg::ONE - t6) + hsa_pkg::HALF) >> 16);
    return p;
  endfunction

  function automatic bit [7:0] rescale(longint unsigned c);
    longint unsigned o;
    o = (c * 255 + hsa_pkg::HALF) >> 16;
    return (o > 255) ? 8'd255 : o[7:0];
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t px);
    longint unsigned r, g, b, mx, mn, d, s, hq, sq, lq, den, n, q, p, h6, full;
    longint hs, v;
    pixel_t res;
    r = px.r; g = px.g; b = px.b;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = mx + mn;
    lq = (s * hsa_pkg::ONE + 255) / 510;
    if (d == 0) begin
      sq = 0;
      hq = 0;
    end else begin
      den = (s <= 255) ? s : 510 - s;
      sq = (d * hsa_pkg::ONE + den / 2) / den;
      if (mx == r) n = (g >= b) ? g - b : 6 * d - (b - g);
      else if (mx == g) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      hq = (n * hsa_pkg::ONE + 3 * d) / (6 * d);
    end
    hs = longint'(hq) + longint'($signed(hue_reg)) * 256;
    if (hs < 0) hs += hsa_pkg::ONE;
    else if (hs > longint'(hsa_pkg::ONE)) hs -= hsa_pkg::ONE;
    hq = longint'(hs) % hsa_pkg::ONE;
    sq = (sq * gain_reg + 128) >> 8;
    if (sq > hsa_pkg::ONE) sq = hsa_pkg::ONE;
    v = $signed(light_reg);
    if (v < 0) lq = (lq * longint'(256 + v) + 128) >> 8;
    else lq = lq + ((longint'(v) * (hsa_pkg::ONE - lq) + 128) >> 8);
    res.a = px.a;
    if (sq == 0) begin
      res.r = rescale(lq);
      res.g = res.r;
      res.b = res.r;
    end else begin
      full = 6 * hsa_pkg::ONE;
      h6 = hq * 6;
      if (lq < hsa_pkg::HALF) q = lq + ((lq * sq + hsa_pkg::HALF) >> 16);
      else q = lq + ((sq * (hsa_pkg::ONE - lq) + hsa_pkg::HALF) >> 16);
      p = 2 * lq - q;
      res.r = rescale(ramp(p, q, (h6 + 2 * hsa_pkg::ONE) % full));
      res.g = rescale(ramp(p, q, h6));
      res.b = rescale(ramp(p, q, (h6 + full - 2 * hsa_pkg::ONE) % full));
    end
    return res;
  endfunction

  class pixel_scoreboard;
    pixel_t pending[$];
    int errors = 0;

    function void note_input(pixel_t px);
      pending.push_back(adjust_pixel(px));
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        $error("unexpected item r=%0d g=%0d b=%0d a=%0d", got.r, got.g, got.b, got.a);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.r !== want.r) begin
        $error("red_out: expected %0d, got %0d", want.r, got.r); errors++;
      end
      if (got.g !== want.g) begin
        $error("green_out: expected %0d, got %0d", want.g, got.g); errors++;
      end
      if (got.b !== want.b) begin
        $error("blue_out: expected %0d, got %0d", want.b, got.b); errors++;
      end
      if (got.a !== want.a) begin
        $error("alpha_out: expected %0d, got %0d", want.a, got.a); errors++;
      end
    endfunction
  endclass

  pixel_scoreboard sb = new();

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // output side: check accepted items, drive random stall stretches
  always @(posedge clk) begin
    pixel_t got;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      got.r = red_out; got.g = green_out; got.b = blue_out; got.a = alpha_out;
      sb.check_result(got);
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (sink_wait != 0) begin
      out_stall <= 1'b1;
      sink_wait <= sink_wait - 1;
    end else if (sink_idle_max != 0 && $urandom_range(0, 9) < sink_idle_max) begin
      out_stall <= 1'b1;
      sink_wait <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** hsl_hue_saturation_adjust: FAILED **");
      $finish;
    end
  end

  // long receiver hold while the sender keeps going
  initial begin
    int unsigned held;
    wait (start_hold);
    @(posedge clk);
    long_hold <= 1'b1;
    held = 0;
    while (held < 80) begin
      @(posedge clk);
      held++;
    end
    long_hold <= 1'b0;
  end

  task automatic send_pixel(pixel_t px, bit with_gap);
    int unsigned idle;
    idle = 0;
    if (with_gap) begin
      idle = gap_len();
      if ($urandom_range(0, 3) == 0) idle = 0;
    end
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= px.r; green_in <= px.g; blue_in <= px.b; alpha_in <= px.a;
    do @(posedge clk); while (in_stall);
    sb.note_input(px);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [9:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      hsa_pkg::REG_HUE_SHIFT: hue_reg = val[8:0];
      hsa_pkg::REG_SAT_GAIN: gain_reg = val;
      hsa_pkg::REG_LIGHT_SHIFT: light_reg = val[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int unsigned mode;
    px.r = 8'($urandom); px.g = 8'($urandom); px.b = 8'($urandom); px.a = 8'($urandom);
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      px.g = px.r; px.b = px.r;
    end else if (mode == 1) begin
      px.r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      px.g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end
    return px;
  endfunction

  initial begin
    pixel_t px;
    bit [9:0] hue_set[6] = '{10'h000, 10'h080, 10'h180, 10'h0FF, 10'h100, 10'h033};
    bit [9:0] gain_set[6] = '{10'd256, 10'd0, 10'd512, 10'd1023, 10'd128, 10'd300};
    bit [9:0] light_set[6] = '{10'h000, 10'h180, 10'h080, 10'h100, 10'h0FF, 10'h1C0};
    bit [7:0] edge_vals[25][4] = '{
      '{0, 0, 0, 0}, '{255, 255, 255, 255}, '{128, 128, 128, 77},
      '{255, 0, 0, 1}, '{0, 255, 0, 2}, '{0, 0, 255, 3},
      '{255, 255, 0, 4}, '{0, 255, 255, 5}, '{255, 0, 255, 6},
      '{255, 0, 1, 7}, '{1, 0, 0, 8}, '{254, 255, 255, 9},
      '{200, 100, 50, 170}, '{50, 200, 100, 85}, '{100, 50, 200, 128},
      '{127, 128, 128, 0}, '{10, 20, 30, 255}, '{255, 1, 0, 254},
      '{0, 1, 255, 16}, '{3, 2, 1, 32}, '{128, 127, 0, 64},
      '{90, 90, 91, 200}, '{255, 254, 0, 99}, '{0, 128, 255, 11}, '{170, 85, 0, 240}};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_vals[i]) begin
      px.r = edge_vals[i][0]; px.g = edge_vals[i][1];
      px.b = edge_vals[i][2]; px.a = edge_vals[i][3];
      send_pixel(px, i % 3 == 0);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(hsa_pkg::REG_HUE_SHIFT, hue_set[phase]);
      write_reg(hsa_pkg::REG_SAT_GAIN, gain_set[phase]);
      write_reg(hsa_pkg::REG_LIGHT_SHIFT, light_set[phase]);
      if (phase == 3) write_reg(REG_UNUSED, 10'h3FF);
      sink_idle_max = (phase == 2) ? 0 : $urandom_range(1, 5);
      // back-to-back items into a receiver that holds off for a long stretch
      if (phase == 2) start_hold = 1'b1;
      for (int i = 0; i < 60; i++) send_pixel(rand_pixel(), phase != 2);
      drain();
    end

    // random register settings, any bit pattern
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(hsa_pkg::REG_HUE_SHIFT, 10'($urandom));
      write_reg(hsa_pkg::REG_SAT_GAIN, 10'($urandom));
      write_reg(hsa_pkg::REG_LIGHT_SHIFT, 10'($urandom));
      sink_idle_max = $urandom_range(0, 5);
      for (int i = 0; i < 90; i++) send_pixel(rand_pixel(), 1'b1);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** hsl_hue_saturation_adjust: PASSED **");
    else
      $display("** hsl_hue_saturation_adjust: FAILED **");
    $finish;
  end

endmodule
